### hw/rtl/npcm_pkg.sv
// Shared constants and types for the nearest palette colour mapper.
`timescale 1ns / 1ps

package npcm_pkg;

   localparam int CHANNEL_BITS = 4;
   localparam int COLOR_BITS   = 3 * CHANNEL_BITS;
   localparam int INDEX_BITS   = 8;
   localparam int CFG_BITS     = 9;
   localparam int DIST_BITS    = $clog2(3 * ((2 ** CHANNEL_BITS - 1) ** 2) + 1);

   localparam logic OP_MAP  = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef struct packed {
      logic [COLOR_BITS-1:0] color;
      logic [INDEX_BITS-1:0] index;
   } map_result_type;

endpackage

### hw/rtl/npcm_palette_ram.sv
// Palette memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module npcm_palette_ram #(
   parameter int DEPTH     = 256,
   parameter int ADDR_BITS = 8
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [ADDR_BITS-1:0]            wr_addr,
   input  logic [npcm_pkg::COLOR_BITS-1:0] wr_data,
   input  logic                            rd_en,
   input  logic [ADDR_BITS-1:0]            rd_addr,
   output logic [npcm_pkg::COLOR_BITS-1:0] rd_data
);
   import npcm_pkg::*;

   logic [COLOR_BITS-1:0] mem [DEPTH];
   logic [COLOR_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/npcm_dist.sv
// Squared RGB distance between two packed colours.
`timescale 1ns / 1ps

module npcm_dist (
   input  logic [npcm_pkg::COLOR_BITS-1:0] color_a,
   input  logic [npcm_pkg::COLOR_BITS-1:0] color_b,
   output logic [npcm_pkg::DIST_BITS-1:0]  sq_dist
);
   import npcm_pkg::*;

   logic [CHANNEL_BITS-1:0]   diff [3];
   logic [2*CHANNEL_BITS-1:0] sq   [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (color_a[c*CHANNEL_BITS +: CHANNEL_BITS] > color_b[c*CHANNEL_BITS +: CHANNEL_BITS])
         begin
            diff[c] = color_a[c*CHANNEL_BITS +: CHANNEL_BITS]
                      - color_b[c*CHANNEL_BITS +: CHANNEL_BITS];
         end else begin
            diff[c] = color_b[c*CHANNEL_BITS +: CHANNEL_BITS]
                      - color_a[c*CHANNEL_BITS +: CHANNEL_BITS];
         end
         sq[c] = (2*CHANNEL_BITS)'(diff[c]) * (2*CHANNEL_BITS)'(diff[c]);
      end
      sq_dist = DIST_BITS'(sq[0]) + DIST_BITS'(sq[1]) + DIST_BITS'(sq[2]);
   end

endmodule

### hw/rtl/npcm_search.sv
// Palette scan engine: one entry read per cycle, exact match or nearest entry.
`timescale 1ns / 1ps

module npcm_search #(
   parameter int ADDR_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [npcm_pkg::COLOR_BITS-1:0] pixel,
   input  logic [ADDR_BITS-1:0]            last_pos,
   output logic                            rd_en,
   output logic [ADDR_BITS-1:0]            rd_addr,
   input  logic [npcm_pkg::COLOR_BITS-1:0] rd_data,
   output logic                            done,
   output npcm_pkg::map_result_type        result
);
   import npcm_pkg::*;

   logic                  busy_ff,      busy_in;
   logic [ADDR_BITS-1:0]  iss_ff,       iss_in;
   logic                  iss_done_ff,  iss_done_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [ADDR_BITS-1:0]  chk_idx_ff,   chk_idx_in;
   logic [COLOR_BITS-1:0] pix_ff,       pix_in;
   logic [ADDR_BITS-1:0]  last_pos_ff,  last_pos_in;
   logic [ADDR_BITS-1:0]  best_idx_ff,  best_idx_in;
   logic [COLOR_BITS-1:0] best_col_ff,  best_col_in;
   logic [DIST_BITS-1:0]  best_d_ff,    best_d_in;

   logic [DIST_BITS-1:0]  cand_dist;
   logic                  match;
   logic                  better;
   logic                  final_chk;

   npcm_dist u_dist (
      .color_a (rd_data),
      .color_b (pix_ff),
      .sq_dist (cand_dist)
   );

   always_comb begin
      match     = chk_valid_ff && (rd_data == pix_ff);
      better    = (chk_idx_ff == '0) || (cand_dist < best_d_ff);
      final_chk = chk_valid_ff && (match || (chk_idx_ff == last_pos_ff));
      rd_en     = busy_ff && !iss_done_ff && !final_chk;
      rd_addr   = iss_ff;
      done      = final_chk;

      if (match) begin
         result.index = INDEX_BITS'(chk_idx_ff);
         result.color = pix_ff;
      end else if (better) begin
         result.index = INDEX_BITS'(chk_idx_ff);
         result.color = rd_data;
      end else begin
         result.index = INDEX_BITS'(best_idx_ff);
         result.color = best_col_ff;
      end

      busy_in      = busy_ff;
      iss_in       = iss_ff;
      iss_done_in  = iss_done_ff;
      pix_in       = pix_ff;
      last_pos_in  = last_pos_ff;
      best_idx_in  = best_idx_ff;
      best_col_in  = best_col_ff;
      best_d_in    = best_d_ff;
      chk_valid_in = rd_en;
      chk_idx_in   = iss_ff;

      if (start) begin
         busy_in     = 1'b1;
         iss_in      = '0;
         iss_done_in = 1'b0;
         pix_in      = pixel;
         last_pos_in = last_pos;
      end else if (final_chk) begin
         busy_in = 1'b0;
      end

      if (rd_en) begin
         if (iss_ff == last_pos_ff) begin
            iss_done_in = 1'b1;
         end else begin
            iss_in = iss_ff + 1'b1;
         end
      end

      if (chk_valid_ff && better) begin
         best_idx_in = chk_idx_ff;
         best_col_in = rd_data;
         best_d_in   = cand_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         iss_done_ff  <= 1'b1;
         chk_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         iss_done_ff  <= iss_done_in;
         chk_valid_ff <= chk_valid_in;
      end
      iss_ff      <= iss_in;
      chk_idx_ff  <= chk_idx_in;
      pix_ff      <= pix_in;
      last_pos_ff <= last_pos_in;
      best_idx_ff <= best_idx_in;
      best_col_ff <= best_col_in;
      best_d_ff   <= best_d_in;
   end

   a_done_while_busy : assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff)
      else $error("scan finished while idle");

   a_check_in_scan : assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> busy_ff)
      else $error("palette data checked outside a scan");

   a_done_single : assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("scan finished twice");

endmodule

### hw/rtl/nearest_palette_color_mapper_top.sv
// Top level of the nearest palette colour mapper: item control, palette, scan, result register.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata: entry_index, entry_color, pixel_color
//          |     |                        | tuser: op, row_start
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: palette_index, mapped_color
//  csr     | in  | csr_we                 | csr_wdata: used_colors
//
// A load item writes the palette and stays in the idle state. A run repeat goes straight to the done state.
// A searched pixel goes through the scan state: one palette read per cycle.
// An exact match ends the scan early.
// Reset clears control, the last colour and index, and sets used_colors to 1.
// A full result register holds a finished item in the done state and keeps req_tready low.
`timescale 1ns / 1ps

module nearest_palette_color_mapper_top #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,  // entry_index, entry_color, pixel_color
   input  logic [1:0]                    req_tuser,  // op, row_start
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [23:0]                   rsp_tdata,  // palette_index, mapped_color, zero pad
   input  logic                          csr_we,
   input  logic [npcm_pkg::CFG_BITS-1:0] csr_wdata
);
   import npcm_pkg::*;

   localparam int ADDR_BITS = $clog2(PALETTE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type             state_ff,      state_in;
   logic [CFG_BITS-1:0]   used_ff,       used_in;
   logic [COLOR_BITS-1:0] last_color_ff, last_color_in;
   logic [INDEX_BITS-1:0] last_index_ff, last_index_in;
   map_result_type        res_ff,        res_in;
   map_result_type        out_ff,        out_in;
   logic                  out_valid_ff,  out_valid_in;

   logic                  req_op;
   logic                  req_row_start;
   logic [INDEX_BITS-1:0] req_entry_index;
   logic [COLOR_BITS-1:0] req_entry_color;
   logic [COLOR_BITS-1:0] req_pixel_color;
   logic                  accept;
   logic                  out_free;

   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   logic                  ram_re;
   logic [ADDR_BITS-1:0]  ram_raddr;
   logic [COLOR_BITS-1:0] ram_rdata;

   logic                  srch_start;
   logic [ADDR_BITS-1:0]  last_pos;
   logic                  srch_done;
   map_result_type        srch_res;

   assign req_op          = req_tuser[0];
   assign req_row_start   = req_tuser[1];
   assign req_entry_index = req_tdata[7:0];
   assign req_entry_color = req_tdata[19:8];
   assign req_pixel_color = req_tdata[31:20];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_ff.color, out_ff.index};

   assign ram_we    = accept && (req_op == OP_LOAD)
                      && (32'(req_entry_index) < 32'(PALETTE_DEPTH));
   assign ram_waddr = ADDR_BITS'(req_entry_index);

   always_comb begin
      if (used_ff == '0) begin
         last_pos = '0;
      end else if (32'(used_ff) > 32'(PALETTE_DEPTH)) begin
         last_pos = ADDR_BITS'(PALETTE_DEPTH - 1);
      end else begin
         last_pos = ADDR_BITS'(used_ff - 1'b1);
      end
   end

   npcm_palette_ram #(
      .DEPTH     (PALETTE_DEPTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_entry_color),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   npcm_search #(
      .ADDR_BITS (ADDR_BITS)
   ) u_search (
      .clock    (clock),
      .reset    (reset),
      .start    (srch_start),
      .pixel    (req_pixel_color),
      .last_pos (last_pos),
      .rd_en    (ram_re),
      .rd_addr  (ram_raddr),
      .rd_data  (ram_rdata),
      .done     (srch_done),
      .result   (srch_res)
   );

   always_comb begin
      state_in      = state_ff;
      used_in       = csr_we ? csr_wdata : used_ff;
      last_color_in = last_color_ff;
      last_index_in = last_index_ff;
      res_in        = res_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      srch_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_MAP)) begin
               if (!req_row_start && (req_pixel_color == last_color_ff)) begin
                  res_in.index = last_index_ff;
                  res_in.color = req_pixel_color;
                  state_in     = ST_DONE;
               end else begin
                  srch_start = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (srch_done) begin
               res_in   = srch_res;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_in        = res_ff;
               out_valid_in  = 1'b1;
               last_color_in = res_ff.color;
               last_index_in = res_ff.index;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= CFG_BITS'(1);
         last_color_ff <= '0;
         last_index_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         last_color_ff <= last_color_in;
         last_index_ff <= last_index_in;
         out_valid_ff  <= out_valid_in;
      end
      res_ff <= res_in;
      out_ff <= out_in;
   end

   a_load_no_scan : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_LOAD)) |=> (state_ff == ST_IDLE))
      else $error("load item started a scan");

   a_result_from_done : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !$past(out_valid_ff && !rsp_tready)) |-> $past(state_ff == ST_DONE))
      else $error("result presented without a finished item");

   a_scan_done_in_scan : assert property (@(posedge clock) disable iff (reset)
      srch_done |-> (state_ff == ST_SCAN))
      else $error("scan finished outside the scan state");

endmodule
